FILE: hw/rtl/bres_pkg.sv
package bres_pkg;

  // Coordinate width used by default on the top level.
  localparam int unsigned COORD_BITS_DEFAULT = 12;

  // Kind of an input item, carried on tuser.
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_NEXT  = 1'b1
  } mode_e;

  // Width of a stream data bus that holds the given number of bits, padded to whole bytes.
  function automatic int unsigned pad_to_bytes(input int unsigned bits);
    pad_to_bytes = ((bits + 7) / 8) * 8;
  endfunction

endpackage

FILE: hw/rtl/bres_setup.sv
module bres_setup #(
  parameter int unsigned COORD_BITS = bres_pkg::COORD_BITS_DEFAULT
) (
  input  logic [COORD_BITS-1:0]        start_x_i,
  input  logic [COORD_BITS-1:0]        start_y_i,
  input  logic [COORD_BITS-1:0]        end_x_i,
  input  logic [COORD_BITS-1:0]        end_y_i,
  output logic [COORD_BITS-1:0]        maj_start_o,
  output logic [COORD_BITS-1:0]        min_start_o,
  output logic [COORD_BITS-1:0]        dmaj_o,
  output logic signed [COORD_BITS+1:0] err_init_o,
  output logic [COORD_BITS:0]          step_straight_o,
  output logic signed [COORD_BITS+1:0] step_diag_o,
  output logic                         swapped_o,
  output logic                         down_o
);

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [COORD_BITS-1:0] p_maj;
  logic [COORD_BITS-1:0] p_min;
  logic [COORD_BITS-1:0] q_maj;
  logic [COORD_BITS-1:0] q_min;
  logic [COORD_BITS-1:0] b_maj;
  logic [COORD_BITS-1:0] b_min;
  logic [COORD_BITS-1:0] dmin;
  logic                  reorder;

  always_comb begin
    adx = (end_x_i > start_x_i) ? (end_x_i - start_x_i) : (start_x_i - end_x_i);
    ady = (end_y_i > start_y_i) ? (end_y_i - start_y_i) : (start_y_i - end_y_i);

    // A tie between the two spans keeps x as the major axis.
    swapped_o = ady > adx;
    if (swapped_o) begin
      p_maj = start_y_i;
      p_min = start_x_i;
      q_maj = end_y_i;
      q_min = end_x_i;
    end else begin
      p_maj = start_x_i;
      p_min = start_y_i;
      q_maj = end_x_i;
      q_min = end_y_i;
    end

    // Walk along the major axis in increasing order.
    reorder = p_maj > q_maj;
    if (reorder) begin
      maj_start_o = q_maj;
      min_start_o = q_min;
      b_maj       = p_maj;
      b_min       = p_min;
    end else begin
      maj_start_o = p_maj;
      min_start_o = p_min;
      b_maj       = q_maj;
      b_min       = q_min;
    end

    dmaj_o = b_maj - maj_start_o;
    down_o = b_min < min_start_o;
    dmin   = down_o ? (min_start_o - b_min) : (b_min - min_start_o);

    step_straight_o = {dmin, 1'b0};
    step_diag_o     = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj_o, 1'b0});
    err_init_o      = $signed({1'b0, dmin, 1'b0}) - $signed({2'b00, dmaj_o});
  end

endmodule

FILE: hw/rtl/bres_walk.sv
module bres_walk #(
  parameter int unsigned COORD_BITS = bres_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  bres_pkg::mode_e              mode_i,
  input  logic [COORD_BITS-1:0]        maj_start_i,
  input  logic [COORD_BITS-1:0]        min_start_i,
  input  logic [COORD_BITS-1:0]        dmaj_i,
  input  logic signed [COORD_BITS+1:0] err_init_i,
  input  logic [COORD_BITS:0]          step_straight_i,
  input  logic signed [COORD_BITS+1:0] step_diag_i,
  input  logic                         swapped_i,
  input  logic                         down_i,
  output logic                         res_valid_o,
  output logic [COORD_BITS-1:0]        pixel_x_o,
  output logic [COORD_BITS-1:0]        pixel_y_o,
  output logic                         last_o
);

  // The state holds the pixel last emitted and the error term before its step.
  logic                         active_q, active_d;
  logic [COORD_BITS-1:0]        maj_q, maj_d;
  logic [COORD_BITS-1:0]        min_q, min_d;
  logic signed [COORD_BITS+1:0] err_q, err_d;
  logic [COORD_BITS:0]          straight_q, straight_d;
  logic signed [COORD_BITS+1:0] diag_q, diag_d;
  logic [COORD_BITS-1:0]        left_q, left_d;
  logic                         swapped_q, swapped_d;
  logic                         down_q, down_d;

  logic [COORD_BITS-1:0]        maj_adv;
  logic [COORD_BITS-1:0]        min_adv;
  logic signed [COORD_BITS+1:0] err_adv;

  always_comb begin
    maj_adv = maj_q + 1'b1;
    if (!err_q[COORD_BITS+1]) begin
      err_adv = err_q + diag_q;
      min_adv = down_q ? (min_q - 1'b1) : (min_q + 1'b1);
    end else begin
      err_adv = err_q + $signed({1'b0, straight_q});
      min_adv = min_q;
    end
  end

  always_comb begin
    active_d    = active_q;
    maj_d       = maj_q;
    min_d       = min_q;
    err_d       = err_q;
    straight_d  = straight_q;
    diag_d      = diag_q;
    left_d      = left_q;
    swapped_d   = swapped_q;
    down_d      = down_q;
    res_valid_o = 1'b0;
    last_o      = 1'b0;

    if (fire_i) begin
      if (mode_i == bres_pkg::MODE_START) begin
        // A new line drops whatever line was in progress.
        maj_d       = maj_start_i;
        min_d       = min_start_i;
        err_d       = err_init_i;
        straight_d  = step_straight_i;
        diag_d      = step_diag_i;
        left_d      = dmaj_i;
        swapped_d   = swapped_i;
        down_d      = down_i;
        active_d    = dmaj_i != '0;
        res_valid_o = 1'b1;
        last_o      = dmaj_i == '0;
      end else if (active_q) begin
        maj_d       = maj_adv;
        min_d       = min_adv;
        err_d       = err_adv;
        left_d      = left_q - 1'b1;
        active_d    = left_q != COORD_BITS'(1);
        res_valid_o = 1'b1;
        last_o      = left_q == COORD_BITS'(1);
      end
    end

    pixel_x_o = swapped_d ? min_d : maj_d;
    pixel_y_o = swapped_d ? maj_d : min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    maj_q      <= maj_d;
    min_q      <= min_d;
    err_q      <= err_d;
    straight_q <= straight_d;
    diag_q     <= diag_d;
    left_q     <= left_d;
    swapped_q  <= swapped_d;
    down_q     <= down_d;
  end

  a_active_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> left_q != '0)
    else $error("line in progress with no pixels left");

  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && mode_i == bres_pkg::MODE_START |-> res_valid_o)
    else $error("start item produced no pixel");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |=> !active_q)
    else $error("line still active after its final pixel");

endmodule

FILE: hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer for all octants. A start item (tuser low) carries two endpoints
// in tdata and yields the first pixel of the line at once; each advance item (tuser high)
// yields the next pixel, and the final pixel of a line comes out with tlast set. An advance
// item with no line in progress yields nothing, and a start item abandons any line still
// being drawn. The block takes one item per clock cycle while the output register is free or
// being drained. An accepted item waits in the input register; then the setup or the error-term
// step updates the line state and loads the output register in the same cycle. The sustained
// rate of one pixel per cycle, when the output does not stall, is set by that error-term add,
// whose result feeds the next item directly.
module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS = bres_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             s_axis_tvalid_i,
  output logic                                             s_axis_tready_o,
  // start_x, start_y, end_x, end_y from the lowest bit up
  input  logic [bres_pkg::pad_to_bytes(4*COORD_BITS)-1:0]  s_axis_tdata_i,
  // mode
  input  logic                                             s_axis_tuser_i,
  output logic                                             m_axis_tvalid_o,
  input  logic                                             m_axis_tready_i,
  // pixel_x, pixel_y from the lowest bit up
  output logic [bres_pkg::pad_to_bytes(2*COORD_BITS)-1:0]  m_axis_tdata_o,
  output logic                                             m_axis_tlast_o
);

  localparam int unsigned C = COORD_BITS;

  logic                  in_valid_q;
  bres_pkg::mode_e       in_mode_q;
  logic [C-1:0]          in_sx_q, in_sy_q, in_ex_q, in_ey_q;
  logic                  proceed;
  logic                  in_take;

  logic                  out_valid_q, out_valid_d;
  logic [C-1:0]          out_x_q, out_y_q;
  logic                  out_last_q;

  logic [C-1:0]          maj_start, min_start, dmaj;
  logic signed [C+1:0]   err_init, step_diag;
  logic [C:0]            step_straight;
  logic                  swapped, down;

  logic                  res_valid, res_last;
  logic [C-1:0]          res_x, res_y;

  // The held item moves on whenever the output register is free or being drained.
  assign proceed         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proceed;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= bres_pkg::mode_e'(s_axis_tuser_i);
      in_sx_q   <= s_axis_tdata_i[C-1:0];
      in_sy_q   <= s_axis_tdata_i[2*C-1:C];
      in_ex_q   <= s_axis_tdata_i[3*C-1:2*C];
      in_ey_q   <= s_axis_tdata_i[4*C-1:3*C];
    end
  end

  bres_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x_i       (in_sx_q),
    .start_y_i       (in_sy_q),
    .end_x_i         (in_ex_q),
    .end_y_i         (in_ey_q),
    .maj_start_o     (maj_start),
    .min_start_o     (min_start),
    .dmaj_o          (dmaj),
    .err_init_o      (err_init),
    .step_straight_o (step_straight),
    .step_diag_o     (step_diag),
    .swapped_o       (swapped),
    .down_o          (down)
  );

  bres_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (proceed),
    .mode_i          (in_mode_q),
    .maj_start_i     (maj_start),
    .min_start_i     (min_start),
    .dmaj_i          (dmaj),
    .err_init_i      (err_init),
    .step_straight_i (step_straight),
    .step_diag_i     (step_diag),
    .swapped_i       (swapped),
    .down_i          (down),
    .res_valid_o     (res_valid),
    .pixel_x_o       (res_x),
    .pixel_y_o       (res_y),
    .last_o          (res_last)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (proceed) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && res_valid) begin
      out_x_q    <= res_x;
      out_y_q    <= res_y;
      out_last_q <= res_last;
    end
  end

  always_comb begin
    m_axis_tdata_o           = '0;
    m_axis_tdata_o[C-1:0]    = out_x_q;
    m_axis_tdata_o[2*C-1:C]  = out_y_q;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !proceed)
    else $error("held result overwritten");

endmodule
